// ----- src/rgb_to_hsv_white_classifier_unit_assert.svh -----
// ----------------------------------------------------------------------------
// RGB to HSV white classifier assertion macros
// Shared helpers for the concurrent checks in the classifier RTL.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_WHITE_CLASSIFIER_UNIT_ASSERT_SVH
`define RGB_TO_HSV_WHITE_CLASSIFIER_UNIT_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RHW_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rgb_to_hsv_white_classifier_unit: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define RHW_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rgb_to_hsv_white_classifier_unit: next-cycle check failed");

`endif

// ----- src/rhw_pkg.sv -----
// ----------------------------------------------------------------------------
// RGB to HSV white classifier package
// Word types and the shared divider step of the classifier pipeline.
// ----------------------------------------------------------------------------
package rhw_pkg;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [12:0] hue;
		logic [7:0]  saturation;
		logic [7:0]  brightness;
		logic        is_white;
	} result_t;

	// One lane of the restoring divider: partial remainder and the
	// dividend bits still to shift in, with quotient bits filling from below.
	typedef struct packed {
		logic [7:0] rem;
		logic [9:0] nq;
	} div_lane_t;

	typedef struct packed {
		logic [7:0] mx;
		logic [7:0] delta;
		logic [1:0] sector;
		logic       neg;
		logic       white;
		div_lane_t  sat;
		div_lane_t  hue;
	} pl_t;

	localparam logic [1:0] SECT_RED   = 2'd0;
	localparam logic [1:0] SECT_GREEN = 2'd1;
	localparam logic [1:0] SECT_BLUE  = 2'd2;

	function automatic div_lane_t div_step(div_lane_t a, logic [7:0] d);
		logic [8:0] t;
		logic       ge;
		div_lane_t  r;
		t = {a.rem, a.nq[9]};
		ge = (t >= {1'b0, d});
		r.rem = ge ? 8'(t - {1'b0, d}) : t[7:0];
		r.nq = {a.nq[8:0], ge};
		return r;
	endfunction

endpackage

// ----- src/rgb_to_hsv_white_classifier_unit.sv -----
// ----------------------------------------------------------------------------
// RGB to HSV white classifier
// Converts a stream of 8-bit RGB pixels to hue, saturation and value and
// flags bright, unsaturated pixels as white.
// ----------------------------------------------------------------------------
// The block takes one pixel word per clock while pixel_ready is high and
// returns one result word per pixel, in order, through a min/max stage, a
// scaling stage, a five-stage divider making the hue and saturation quotients
// two bits per stage, and the output register. Every stage holds its word
// while the next is full and stalled, so pixel_ready drops only when all eight
// stages hold a word and result_ready is low. The user writes thresholds over
// the APB port only while no pixel is in flight; the block does not check it.
`include "rgb_to_hsv_white_classifier_unit_assert.svh"

module rgb_to_hsv_white_classifier_unit import rhw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pixel_valid,
	output logic        pixel_ready,
	input  pixel_t      pixel,
	output logic        result_valid,
	input  logic        result_ready,
	output result_t     result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int NSTG = 8;
	localparam int NDIV = 5;

	localparam logic        REG_VALUE     = 1'b0;
	localparam logic        REG_SAT       = 1'b1;
	localparam logic [9:0]  VALUE_THR_RST = 10'd650;
	localparam logic [9:0]  SAT_THR_RST   = 10'd200;
	localparam logic [17:0] MILLI         = 18'd1000;
	localparam logic [17:0] FULL_SCALE    = 18'd255;
	localparam logic [17:0] HUE_SCALE     = 18'd960;
	localparam logic [12:0] HUE_FULL      = 13'd5760;
	localparam logic [12:0] HUE_OFS_GREEN = 13'd1920;
	localparam logic [12:0] HUE_OFS_BLUE  = 13'd3840;

	logic [9:0] value_thr_q;
	logic [9:0] sat_thr_q;

	logic [NSTG:1] vld_s;
	logic [NSTG:1] adv;
	logic [NSTG:0] vld_chain;

	logic [7:0]  mx_c;
	logic [7:0]  mn_c;
	logic [1:0]  sector_c;
	logic [8:0]  diff_c;
	logic [7:0]  mx_s1;
	logic [7:0]  delta_s1;
	logic [1:0]  sector_s1;
	logic        neg_s1;
	logic [7:0]  absnum_s1;

	logic [17:0] sat_n;
	logic [17:0] hue_n;
	logic        white_c;
	pl_t         pl_c;
	pl_t         pl_s2;
	pl_t         div_pl [NDIV+1];

	pl_t         fin;
	logic [12:0] q_c;
	logic [12:0] hue_c;
	result_t     result_s8;

	// Configuration registers.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_thr_q <= VALUE_THR_RST;
			sat_thr_q <= SAT_THR_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_VALUE: value_thr_q <= pwdata[9:0];
				REG_SAT:   sat_thr_q <= pwdata[9:0];
				default:   value_thr_q <= value_thr_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_VALUE: prdata = {22'd0, value_thr_q};
			REG_SAT:   prdata = {22'd0, sat_thr_q};
			default:   prdata = 32'd0;
		endcase
	end

	// Pipeline flow control: a stage loads when it is empty or its word moves on.
	always_comb begin
		adv[NSTG] = !vld_s[NSTG] || result_ready;
		for (int k = NSTG - 1; k >= 1; k--) begin
			adv[k] = !vld_s[k] || adv[k+1];
		end
	end

	assign vld_chain = {vld_s, pixel_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 1; k <= NSTG; k++) begin
				if (adv[k]) begin
					vld_s[k] <= vld_chain[k-1];
				end
			end
		end
	end

	assign pixel_ready = adv[1];

	// Stage 1: max, min, delta, sector and hue numerator.
	always_comb begin
		mx_c = pixel.red;
		if (pixel.green > mx_c) begin
			mx_c = pixel.green;
		end
		if (pixel.blue > mx_c) begin
			mx_c = pixel.blue;
		end
		mn_c = pixel.red;
		if (pixel.green < mn_c) begin
			mn_c = pixel.green;
		end
		if (pixel.blue < mn_c) begin
			mn_c = pixel.blue;
		end
		if (mx_c == pixel.red) begin
			sector_c = SECT_RED;
			diff_c = {1'b0, pixel.green} - {1'b0, pixel.blue};
		end else if (mx_c == pixel.green) begin
			sector_c = SECT_GREEN;
			diff_c = {1'b0, pixel.blue} - {1'b0, pixel.red};
		end else begin
			sector_c = SECT_BLUE;
			diff_c = {1'b0, pixel.red} - {1'b0, pixel.green};
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			mx_s1 <= mx_c;
			delta_s1 <= mx_c - mn_c;
			sector_s1 <= sector_c;
			neg_s1 <= diff_c[8];
			absnum_s1 <= diff_c[8] ? 8'(-diff_c) : diff_c[7:0];
		end
	end

	// Stage 2: scaled dividends, white decision and divider setup.
	always_comb begin
		sat_n = {10'd0, delta_s1} * FULL_SCALE;
		hue_n = {10'd0, absnum_s1} * HUE_SCALE;
		white_c = (({10'd0, mx_s1} * MILLI) > ({8'd0, value_thr_q} * FULL_SCALE)) &&
			(({10'd0, delta_s1} * MILLI) < ({8'd0, sat_thr_q} * {10'd0, mx_s1}));
		pl_c.mx = mx_s1;
		pl_c.delta = delta_s1;
		pl_c.sector = sector_s1;
		pl_c.neg = neg_s1;
		pl_c.white = white_c;
		pl_c.sat.rem = sat_n[17:10];
		pl_c.sat.nq = sat_n[9:0];
		pl_c.hue.rem = hue_n[17:10];
		pl_c.hue.nq = hue_n[9:0];
	end

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			pl_s2 <= pl_c;
		end
	end

	// Stages 3 to 7: the divider.
	assign div_pl[0] = pl_s2;

	for (genvar i = 0; i < NDIV; i++) begin : g_div
		rhw_div_stage u_div (
			.clk (clk),
			.en  (adv[3+i]),
			.d   (div_pl[i]),
			.q   (div_pl[i+1])
		);
	end

	// Stage 8: hue offset and wrap, gray pixels, output register.
	assign fin = div_pl[NDIV];
	assign q_c = {3'd0, fin.hue.nq};

	always_comb begin
		case (fin.sector)
			SECT_RED:   hue_c = fin.neg ? HUE_FULL - q_c : q_c;
			SECT_GREEN: hue_c = fin.neg ? HUE_OFS_GREEN - q_c : HUE_OFS_GREEN + q_c;
			SECT_BLUE:  hue_c = fin.neg ? HUE_OFS_BLUE - q_c : HUE_OFS_BLUE + q_c;
			default:    hue_c = 13'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv[NSTG]) begin
			result_s8.hue <= (fin.delta == 8'd0) ? 13'd0 : hue_c;
			result_s8.saturation <= (fin.delta == 8'd0) ? 8'd0 : fin.sat.nq[7:0];
			result_s8.brightness <= fin.mx;
			result_s8.is_white <= fin.white;
		end
	end

	assign result_valid = vld_s[NSTG];
	assign result = result_s8;

	`RHW_ASSERT_IMP(a_hue_range, result_valid, result.hue < HUE_FULL)
	`RHW_ASSERT_IMP(a_black_is_gray, result_valid && result.brightness == 8'd0,
		result.hue == 13'd0 && result.saturation == 8'd0)
	`RHW_ASSERT_IMP(a_white_is_lit, result_valid && result.is_white, result.brightness != 8'd0)
	`RHW_ASSERT_IMP(a_full_when_blocked, !pixel_ready, vld_s == '1 && !result_ready)
	`RHW_ASSERT_NXT(a_stall_keeps_word, vld_s[1] && !adv[1], vld_s[1])

endmodule

// ----- src/rhw_div_stage.sv -----
// ----------------------------------------------------------------------------
// RGB to HSV white classifier divider stage
// One pipeline stage that retires two quotient bits on both divider lanes.
// ----------------------------------------------------------------------------
module rhw_div_stage import rhw_pkg::*; (
	input  logic clk,
	input  logic en,
	input  pl_t  d,
	output pl_t  q
);

	pl_t nxt;
	pl_t div_s;

	always_comb begin
		nxt = d;
		nxt.sat = div_step(div_step(d.sat, d.mx), d.mx);
		nxt.hue = div_step(div_step(d.hue, d.delta), d.delta);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s <= nxt;
		end
	end

	assign q = div_s;

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RGB to HSV white classifier testbench
// Streams directed and random pixels through the classifier under a series
// of threshold settings, with random gaps on both sides and a long result
// stall, and checks every result word against an in-bench prediction.
// ----------------------------------------------------------------------------
module tb_top;
	import rhw_pkg::*;

	localparam int REG_VALUE_TH = 0;
	localparam int REG_SAT_TH   = 1;
	localparam int HUE_SECTOR   = 960;
	localparam int HUE_TURN     = 5760;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASES       = 9;
	localparam int PER_PHASE    = 175;
	localparam int N_DIRECTED   = 25;

	class hsv_scoreboard;
		result_t    expected[$];
		logic [9:0] value_th;
		logic [9:0] sat_th;
		int         mismatches;
		int         results_seen;
		int         white_seen;
		int         gray_seen;

		function new();
			value_th = 10'd650;
			sat_th = 10'd200;
		endfunction

		function void set_threshold(int idx, logic [9:0] val);
			if (idx == REG_VALUE_TH) begin
				value_th = val;
			end else if (idx == REG_SAT_TH) begin
				sat_th = val;
			end
		endfunction

		function void report(string what);
			if (mismatches < 10) begin
				$display("mismatch: %s", what);
			end
			mismatches++;
		endfunction

		function void note_pixel(pixel_t p);
			int r, g, b, mx, mn, delta, h, s, vt, st;
			result_t e;
			r = p.red;
			g = p.green;
			b = p.blue;
			mx = r;
			mn = r;
			if (g > mx) mx = g;
			if (b > mx) mx = b;
			if (g < mn) mn = g;
			if (b < mn) mn = b;
			delta = mx - mn;
			h = 0;
			s = 0;
			if (delta > 0) begin
				s = (255 * delta) / mx;
				if (mx == r) begin
					h = (HUE_SECTOR * (g - b)) / delta;
					if (h < 0) h += HUE_TURN;
				end else if (mx == g) begin
					h = 2 * HUE_SECTOR + (HUE_SECTOR * (b - r)) / delta;
				end else begin
					h = 4 * HUE_SECTOR + (HUE_SECTOR * (r - g)) / delta;
				end
			end else begin
				gray_seen++;
			end
			vt = value_th;
			st = sat_th;
			e.hue = 13'(h);
			e.saturation = 8'(s);
			e.brightness = 8'(mx);
			e.is_white = (mx * 1000 > vt * 255) && (delta * 1000 < st * mx);
			if (e.is_white) white_seen++;
			expected.insert(expected.size(), e);
		endfunction

		function void check_result(result_t r);
			result_t e;
			results_seen++;
			if (expected.size() == 0) begin
				report($sformatf("result with nothing expected: hue %0d sat %0d val %0d white %0d",
					r.hue, r.saturation, r.brightness, r.is_white));
				return;
			end
			e = expected.pop_front();
			if (r.hue !== e.hue || r.saturation !== e.saturation ||
			    r.brightness !== e.brightness || r.is_white !== e.is_white) begin
				report($sformatf("hue %0d/%0d sat %0d/%0d val %0d/%0d white %0d/%0d (exp/act)",
					e.hue, r.hue, e.saturation, r.saturation,
					e.brightness, r.brightness, e.is_white, r.is_white));
			end
		endfunction

		function void check_readback(int idx, logic [31:0] rd);
			logic [31:0] want;
			want = (idx == REG_VALUE_TH) ? 32'(value_th) : 32'(sat_th);
			if (rd !== want) begin
				report($sformatf("register %0d read %0h, expected %0h", idx, rd, want));
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        pixel_valid;
	logic        pixel_ready;
	pixel_t      pixel;
	logic        result_valid;
	logic        result_ready;
	result_t     result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	hsv_scoreboard sb = new();
	bit idle_tx;
	bit idle_rx;
	int hold_cycles;
	int cycles;
	int settings_done;

	rgb_to_hsv_white_classifier_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.pixel_valid(pixel_valid),
		.pixel_ready(pixel_ready),
		.pixel(pixel),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (pixel_valid && pixel_ready) sb.note_pixel(pixel);
			if (result_valid && result_ready) sb.check_result(result);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	initial begin : result_sink
		int stall;
		wait (arst_n);
		forever begin
			stall = idle_rx ? $urandom_range(0, 6) : 0;
			if (hold_cycles > 0) begin
				stall = hold_cycles;
				hold_cycles = 0;
			end
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
		end
	end

	task automatic send_pixel(pixel_t p);
		int gap;
		gap = idle_tx ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel_valid <= 1'b1;
		pixel <= p;
		do @(posedge clk); while (!pixel_ready);
	endtask

	task automatic stop_pixels();
		pixel_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (sb.expected.size() != 0) @(posedge clk);
	endtask

	task automatic write_threshold(int idx, logic [9:0] val);
		logic [31:0] data;
		data = {($urandom_range(0, 1) ? 22'($urandom) : 22'd0), val};
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(4 * idx);
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_threshold(idx, val);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.check_readback(idx, prdata);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [7:0] jitter(int base, int spread);
		int v;
		v = base + $urandom_range(0, 2 * spread) - spread;
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		return 8'(v);
	endfunction

	function automatic logic [7:0] extreme_byte();
		int k;
		k = $urandom_range(0, 2);
		return (k == 0) ? 8'd0 : (k == 1) ? 8'd255 : 8'($urandom);
	endfunction

	function automatic pixel_t rand_pixel();
		int kind, base, spread, top, low, odd;
		pixel_t p;
		kind = $urandom_range(0, 99);
		if (kind < 40) begin
			p = pixel_t'(24'($urandom));
		end else if (kind < 75) begin
			base = (kind < 60) ? $urandom_range(0, 255) : $urandom_range(160, 255);
			spread = $urandom_range(0, 12);
			p.red = jitter(base, spread);
			p.green = jitter(base, spread);
			p.blue = jitter(base, spread);
		end else if (kind < 90) begin
			p.red = extreme_byte();
			p.green = extreme_byte();
			p.blue = extreme_byte();
		end else begin
			top = $urandom_range(1, 255);
			low = $urandom_range(0, top - 1);
			odd = $urandom_range(0, 2);
			p.red = 8'((odd == 0) ? low : top);
			p.green = 8'((odd == 1) ? low : top);
			p.blue = 8'((odd == 2) ? low : top);
		end
		return p;
	endfunction

	initial begin : stimulus
		logic [23:0] directed[N_DIRECTED];
		logic [9:0] value_set[PHASES];
		logic [9:0] sat_set[PHASES];
		logic [9:0] vth, sth;

		directed = '{
			24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101, 24'hFF0000,
			24'h00FF00, 24'h0000FF, 24'hFF0001, 24'hFFFF00, 24'h00FFFF,
			24'hFF00FF, 24'h010000, 24'h000100, 24'h000001, 24'hFEFFFF,
			24'hFFFEFE, 24'hAA5500, 24'h0055AA, 24'h5500AA, 24'hFFFFFE,
			24'hE6E6C8, 24'hA6A6A6, 24'hA5A5A5, 24'h55FF00, 24'hFF8000
		};
		value_set = '{10'd0, 10'd1000, 10'd1023, 10'd0, 10'd1023,
			10'd200, 10'd650, 10'd0, 10'd0};
		sat_set = '{10'd0, 10'd1000, 10'd1023, 10'd1023, 10'd0,
			10'd500, 10'd200, 10'd0, 10'd0};

		clk = 1'b0;
		arst_n = 1'b0;
		pixel_valid = 1'b0;
		pixel = '0;
		result_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		idle_tx = 1'b1;
		idle_rx = 1'b1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) send_pixel(pixel_t'(directed[i]));
		stop_pixels();
		wait_drained();
		settings_done = 1;

		for (int ph = 0; ph < PHASES; ph++) begin
			vth = (ph >= 7) ? 10'($urandom_range(0, 1023)) : value_set[ph];
			sth = (ph >= 7) ? 10'($urandom_range(0, 1023)) : sat_set[ph];
			write_threshold(REG_VALUE_TH, vth);
			write_threshold(REG_SAT_TH, sth);
			settings_done++;
			idle_tx = (ph % 4 == 0) || (ph % 4 == 2);
			idle_rx = (ph % 4 == 0) || (ph % 4 == 1);
			for (int n = 0; n < PER_PHASE; n++) begin
				if (ph == 3 && n == 40) begin
					idle_tx = 1'b0;
					hold_cycles = 300;
				end
				if (ph == 5 && n == 90) begin
					stop_pixels();
					wait_drained();
				end
				send_pixel(rand_pixel());
			end
			stop_pixels();
			wait_drained();
		end

		repeat (20) @(posedge clk);
		$display("Checked %0d result words over %0d threshold settings.",
			sb.results_seen, settings_done);
		$display("Of those, %0d were flagged white and %0d were gray.",
			sb.white_seen, sb.gray_seen);
		if (sb.mismatches == 0 && sb.expected.size() == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
